/* src/assert_macros.svh */
// Assertion macros shared by the RTL of the TCP header parser.
// Build with NO_ASSERTIONS defined to drop every check.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Checked on every rising edge of clk_i, ignored while rst_ni is low.
`define ASSERT_ON_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Checked on every rising edge of clk_i, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define ASSERT_ON_CLK(lbl, prop, msg)
`define ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

/* src/tcpp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcpp_pkg
// Types, codes and helper functions of the TCP header and option parser.
// ----------------------------------------------------------------------------
package tcpp_pkg;

  // Byte counting saturates here.
  localparam logic [15:0] MAX_SEG_BYTES = 16'd65535;

  // Record queue between the parser and the output port.
  localparam int unsigned RQ_DEPTH = 4;
  localparam int unsigned RQ_PTR_W = $clog2(RQ_DEPTH);
  localparam int unsigned RQ_CNT_W = $clog2(RQ_DEPTH + 1);

  typedef enum logic [3:0] {
    REC_PORTS     = 4'd0,
    REC_SEQ       = 4'd1,
    REC_ACK       = 4'd2,
    REC_HDR_FLAGS = 4'd3,
    REC_WIN_CSUM  = 4'd4,
    REC_URGENT    = 4'd5,
    REC_NOP       = 4'd6,
    REC_MSS       = 4'd7,
    REC_WSCALE    = 4'd8,
    REC_SACK_OK   = 4'd9,
    REC_TSTAMP    = 4'd10,
    REC_UNKNOWN   = 4'd11,
    REC_MALFORMED = 4'd12,
    REC_END       = 4'd13
  } rec_kind_e;

  typedef enum logic [2:0] {
    APP_NONE   = 3'd0,
    APP_HTTP   = 3'd1,
    APP_TELNET = 3'd2,
    APP_SMTP   = 3'd3,
    APP_POP    = 3'd4,
    APP_IMAP   = 3'd5,
    APP_FTP    = 3'd6
  } app_class_e;

  // Reasons carried by a malformed record.
  localparam logic [31:0] BAD_DATA_OFFSET = 32'd1;
  localparam logic [31:0] BAD_OPT_LENGTH  = 32'd2;
  localparam logic [31:0] OPT_PAST_END    = 32'd3;
  localparam logic [31:0] SHORT_SEGMENT   = 32'd4;

  // Option kinds.
  localparam logic [7:0] OPT_EOL     = 8'd0;
  localparam logic [7:0] OPT_NOP     = 8'd1;
  localparam logic [7:0] OPT_MSS     = 8'd2;
  localparam logic [7:0] OPT_WSCALE  = 8'd3;
  localparam logic [7:0] OPT_SACK_OK = 8'd4;
  localparam logic [7:0] OPT_TSTAMP  = 8'd8;

  typedef struct packed {
    rec_kind_e   kind;
    logic [31:0] val_a;
    logic [31:0] val_b;
    app_class_e  app_class;
    logic        last;
  } rec_t;

  // Up to two records written into the queue in one cycle.
  typedef struct packed {
    logic [1:0] count;
    rec_t       rec0;
    rec_t       rec1;
  } push_t;

  function automatic rec_t make_rec(rec_kind_e kind, logic [31:0] a, logic [31:0] b,
                                    app_class_e cls, logic last);
    rec_t r;
    r.kind      = kind;
    r.val_a     = a;
    r.val_b     = b;
    r.app_class = cls;
    r.last      = last;
    return r;
  endfunction

  function automatic app_class_e port_class(logic [15:0] port);
    app_class_e c;
    case (port)
      16'd80:         c = APP_HTTP;
      16'd23:         c = APP_TELNET;
      16'd25:         c = APP_SMTP;
      16'd110:        c = APP_POP;
      16'd143:        c = APP_IMAP;
      16'd20, 16'd21: c = APP_FTP;
      default:        c = APP_NONE;
    endcase
    return c;
  endfunction

  // Record for a completed option; held carries value bytes 2..5 and
  // shift carries value bytes 6..9.
  function automatic rec_t option_rec(logic [7:0] otype, logic [7:0] olen,
                                      logic [31:0] held, logic [31:0] shift);
    rec_t r;
    case (otype)
      OPT_MSS:     r = make_rec(REC_MSS, {16'd0, held[31:16]}, {24'd0, olen}, APP_NONE, 1'b0);
      OPT_WSCALE:  r = make_rec(REC_WSCALE, {24'd0, held[31:24]}, {24'd0, olen}, APP_NONE,
                                1'b0);
      OPT_SACK_OK: r = make_rec(REC_SACK_OK, 32'd0, {24'd0, olen}, APP_NONE, 1'b0);
      OPT_TSTAMP:  r = make_rec(REC_TSTAMP, held, shift, APP_NONE, 1'b0);
      default:     r = make_rec(REC_UNKNOWN, {24'd0, otype}, {24'd0, olen}, APP_NONE, 1'b0);
    endcase
    return r;
  endfunction

endpackage

/* src/tcpp_rec_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcpp_rec_fifo
// Small record queue: takes up to two records per cycle, gives one per beat.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tcpp_rec_fifo
  import tcpp_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  push_t push_i,
  output logic  space_o,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output rec_t  rec_o
);

  rec_t                mem [RQ_DEPTH];
  logic [RQ_PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [RQ_CNT_W-1:0] count_q, count_d;
  logic                pop;

  // Room for the worst case of two records from the next byte.
  assign space_o     = (count_q <= RQ_CNT_W'(RQ_DEPTH - 2));
  assign out_valid_o = (count_q != '0);
  assign pop         = out_valid_o && out_ready_i;
  assign rec_o       = mem[rd_q];

  always_comb begin
    wr_d    = wr_q + RQ_PTR_W'(push_i.count);
    rd_d    = rd_q + RQ_PTR_W'(pop);
    count_d = count_q + RQ_CNT_W'(push_i.count) - RQ_CNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      wr_q    <= wr_d;
      rd_q    <= rd_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem[wr_q] <= push_i.rec0;
    end
    if (push_i.count == 2'd2) begin
      mem[wr_q + RQ_PTR_W'(1)] <= push_i.rec1;
    end
  end

  `ASSERT_ALWAYS(fifo_count_bound, count_q <= RQ_CNT_W'(RQ_DEPTH), "record queue count overflow")
  `ASSERT_ON_CLK(fifo_no_overrun, push_i.count != 2'd0 |-> space_o, "push without room")
  `ASSERT_ON_CLK(fifo_double_push, (push_i.count == 2'd2) && !pop |=> count_q == $past(count_q) + RQ_CNT_W'(2), "double push miscounted")

endmodule

/* src/tcp_header_option_parser_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcp_header_option_parser_core
// Output: a record is written into the record queue when the byte that
//   completes it is accepted, and is shown once it reaches the queue head.
// Throughput: one byte per cycle; a byte may give up to two records, and the
//   four-entry record queue takes a byte only while it has room for two.
// Reset: asynchronous and active low; clears all parse state and the queue.
//
// Parses a TCP segment that arrives one byte per beat and emits tagged
// records as header fields and options complete.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tcp_header_option_parser_core
  import tcpp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        seg_last_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  record_kind_o,
  output logic [31:0] value_a_o,
  output logic [31:0] value_b_o,
  output logic [2:0]  app_class_o,
  output logic        rec_last_o
);

  // Option walker: expecting a kind byte, a length byte, or value bytes.
  typedef enum logic [2:0] {
    PH_TYPE  = 3'b001,
    PH_LEN   = 3'b010,
    PH_VALUE = 3'b100
  } opt_phase_e;

  // Byte positions at which fixed header fields complete.
  localparam logic [4:0] POS_PORTS  = 5'd3;
  localparam logic [4:0] POS_SEQ    = 5'd7;
  localparam logic [4:0] POS_ACK    = 5'd11;
  localparam logic [4:0] POS_OFFSET = 5'd13;
  localparam logic [4:0] POS_WINDOW = 5'd17;
  localparam logic [4:0] POS_URGENT = 5'd19;
  localparam logic [5:0] FIXED_HDR  = 6'd20;

  logic [15:0] pos_q, pos_d;
  logic [5:0]  hb_q, hb_d;
  logic [31:0] fs_q, fs_d;
  logic [31:0] held_q, held_d;
  app_class_e  cls_q, cls_d;
  opt_phase_e  phase_q, phase_d;
  logic [7:0]  otype_q, otype_d;
  logic [7:0]  olen_q, olen_d;
  logic [7:0]  oidx_q, oidx_d;
  logic        done_q, done_d;

  logic        in_fire;
  logic [5:0]  hdr_end, hdr_end_new;
  logic [15:0] total;
  app_class_e  cls_tmp;
  logic [3:0]  offset;
  rec_t        p0, p1, fin;
  logic        v0, v1;
  push_t       push;
  logic        space;
  rec_t        head;

  assign in_ready_o = space;
  assign in_fire    = in_valid_i && in_ready_o;

  // The header ends at the larger of 20 bytes and the data offset in bytes.
  assign hdr_end = (hb_q < FIXED_HDR) ? FIXED_HDR : hb_q;

  always_comb begin
    pos_d   = pos_q;
    hb_d    = hb_q;
    fs_d    = fs_q;
    held_d  = held_q;
    cls_d   = cls_q;
    phase_d = phase_q;
    otype_d = otype_q;
    olen_d  = olen_q;
    oidx_d  = oidx_q;
    done_d  = done_q;
    cls_tmp = APP_NONE;
    offset  = 4'd0;
    p0      = '0;
    p1      = '0;
    v0      = 1'b0;
    v1      = 1'b0;

    if (pos_q < 16'(FIXED_HDR)) begin
      // Fixed header: bytes shift through one word and fields are cut from it.
      fs_d = {fs_q[23:0], data_byte_i};
      case (pos_q[4:0])
        POS_PORTS: begin
          // The source port is tried first; the destination only if it gives nothing.
          cls_tmp = port_class(fs_d[31:16]);
          if (cls_tmp == APP_NONE) begin
            cls_tmp = port_class(fs_d[15:0]);
          end
          cls_d = cls_tmp;
          v0    = 1'b1;
          p0    = make_rec(REC_PORTS, {16'd0, fs_d[31:16]}, {16'd0, fs_d[15:0]}, cls_tmp, 1'b0);
        end
        POS_SEQ: begin
          v0 = 1'b1;
          p0 = make_rec(REC_SEQ, fs_d, 32'd0, APP_NONE, 1'b0);
        end
        POS_ACK: begin
          v0 = 1'b1;
          p0 = make_rec(REC_ACK, fs_d, 32'd0, APP_NONE, 1'b0);
        end
        POS_OFFSET: begin
          offset = fs_d[15:12];
          hb_d   = {offset, 2'b00};
          v0     = 1'b1;
          p0     = make_rec(REC_HDR_FLAGS, {26'd0, hb_d}, {24'd0, fs_d[7:0]}, APP_NONE, 1'b0);
          // A data offset below five words shuts off option parsing; the
          // complaint is dropped when the segment also ends on this byte.
          if (offset < 4'd5) begin
            done_d = 1'b1;
            if (!seg_last_i) begin
              v1 = 1'b1;
              p1 = make_rec(REC_MALFORMED, BAD_DATA_OFFSET, {28'd0, offset}, APP_NONE, 1'b0);
            end
          end
        end
        POS_WINDOW: begin
          v0 = 1'b1;
          p0 = make_rec(REC_WIN_CSUM, {16'd0, fs_d[31:16]}, {16'd0, fs_d[15:0]}, APP_NONE,
                        1'b0);
        end
        POS_URGENT: begin
          v0 = 1'b1;
          p0 = make_rec(REC_URGENT, {16'd0, fs_d[15:0]}, 32'd0, APP_NONE, 1'b0);
        end
        default: begin
        end
      endcase
    end else if ((pos_q < {10'd0, hdr_end}) && !done_q) begin
      unique case (phase_q)
        PH_TYPE: begin
          if (data_byte_i == OPT_EOL) begin
            done_d = 1'b1;
          end else if (data_byte_i == OPT_NOP) begin
            v0 = 1'b1;
            p0 = make_rec(REC_NOP, 32'd1, 32'd1, APP_NONE, 1'b0);
          end else begin
            otype_d = data_byte_i;
            phase_d = PH_LEN;
          end
        end
        PH_LEN: begin
          olen_d = data_byte_i;
          if (data_byte_i < 8'd2) begin
            done_d = 1'b1;
            v0     = 1'b1;
            p0     = make_rec(REC_MALFORMED, BAD_OPT_LENGTH, {24'd0, data_byte_i}, APP_NONE,
                              1'b0);
          end else if (({1'b0, pos_q} + {9'd0, data_byte_i} - 17'd1) > {11'd0, hdr_end}) begin
            // The option would run past the end of the header.
            done_d = 1'b1;
            v0     = 1'b1;
            p0     = make_rec(REC_MALFORMED, OPT_PAST_END, {24'd0, data_byte_i}, APP_NONE,
                              1'b0);
          end else begin
            held_d = 32'd0;
            fs_d   = 32'd0;
            if (data_byte_i == 8'd2) begin
              v0      = 1'b1;
              p0      = option_rec(otype_q, data_byte_i, 32'd0, 32'd0);
              phase_d = PH_TYPE;
            end else begin
              oidx_d  = 8'd2;
              phase_d = PH_VALUE;
            end
          end
        end
        PH_VALUE: begin
          // Value bytes 2..5 go to the held word, 6..9 to the shift word,
          // most significant first; later bytes are skipped.
          case (oidx_q)
            8'd2:    held_d[31:24] = held_q[31:24] | data_byte_i;
            8'd3:    held_d[23:16] = held_q[23:16] | data_byte_i;
            8'd4:    held_d[15:8]  = held_q[15:8]  | data_byte_i;
            8'd5:    held_d[7:0]   = held_q[7:0]   | data_byte_i;
            8'd6:    fs_d[31:24]   = fs_q[31:24]   | data_byte_i;
            8'd7:    fs_d[23:16]   = fs_q[23:16]   | data_byte_i;
            8'd8:    fs_d[15:8]    = fs_q[15:8]    | data_byte_i;
            8'd9:    fs_d[7:0]     = fs_q[7:0]     | data_byte_i;
            default: begin
            end
          endcase
          if (({1'b0, oidx_q} + 9'd1) >= {1'b0, olen_q}) begin
            v0      = 1'b1;
            p0      = option_rec(otype_q, olen_q, held_d, fs_d);
            phase_d = PH_TYPE;
          end else begin
            oidx_d = oidx_q + 8'd1;
          end
        end
        default: begin
          phase_d = PH_TYPE;
        end
      endcase
    end

    // Closing record; the length is measured against the header end as it
    // stands after this byte.
    total       = (pos_q == MAX_SEG_BYTES) ? pos_q : pos_q + 16'd1;
    hdr_end_new = (hb_d < FIXED_HDR) ? FIXED_HDR : hb_d;
    if (total < {10'd0, hdr_end_new}) begin
      fin = make_rec(REC_MALFORMED, SHORT_SEGMENT, {16'd0, total}, APP_NONE, 1'b1);
    end else begin
      fin = make_rec(REC_END, {16'd0, total - {10'd0, hdr_end_new}}, {16'd0, total}, cls_d,
                     1'b1);
    end

    if (seg_last_i) begin
      pos_d   = '0;
      hb_d    = '0;
      fs_d    = '0;
      held_d  = '0;
      cls_d   = APP_NONE;
      phase_d = PH_TYPE;
      otype_d = '0;
      olen_d  = '0;
      oidx_d  = '0;
      done_d  = 1'b0;
    end else if (pos_q < MAX_SEG_BYTES) begin
      pos_d = pos_q + 16'd1;
    end

    // Pack the records of this byte into the queue write.
    push = '0;
    if (in_fire) begin
      if (v0) begin
        push.rec0  = p0;
        push.rec1  = v1 ? p1 : fin;
        push.count = 2'd1 + 2'(v1) + 2'(seg_last_i);
      end else begin
        push.rec0  = fin;
        push.count = 2'(seg_last_i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      hb_q    <= '0;
      fs_q    <= '0;
      held_q  <= '0;
      cls_q   <= APP_NONE;
      phase_q <= PH_TYPE;
      otype_q <= '0;
      olen_q  <= '0;
      oidx_q  <= '0;
      done_q  <= 1'b0;
    end else if (in_fire) begin
      pos_q   <= pos_d;
      hb_q    <= hb_d;
      fs_q    <= fs_d;
      held_q  <= held_d;
      cls_q   <= cls_d;
      phase_q <= phase_d;
      otype_q <= otype_d;
      olen_q  <= olen_d;
      oidx_q  <= oidx_d;
      done_q  <= done_d;
    end
  end

  // The queue parts the byte side from the record side, so a byte is taken
  // while an earlier record still waits on the output.
  tcpp_rec_fifo u_rec_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .space_o     (space),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .rec_o       (head)
  );

  assign record_kind_o = head.kind;
  assign value_a_o     = head.val_a;
  assign value_b_o     = head.val_b;
  assign app_class_o   = head.app_class;
  assign rec_last_o    = head.last;

  `ASSERT_ON_CLK(last_rec_closes, out_valid_o && rec_last_o |-> (record_kind_o == REC_END || record_kind_o == REC_MALFORMED), "last flag on a non-closing record")
  `ASSERT_ON_CLK(class_on_ports_end, out_valid_o && (app_class_o != APP_NONE) |-> (record_kind_o == REC_PORTS || record_kind_o == REC_END), "class on wrong record")
  `ASSERT_ON_CLK(segment_end_clears, in_fire && seg_last_i |=> (pos_q == 16'd0) && !done_q && (phase_q == PH_TYPE), "state not cleared after segment end")

endmodule

/* tb/tb_tcp_header_option_parser_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tcp_header_option_parser_core
// Self-checking bench for the TCP header and option parser.
// TCP segments go in one byte per beat, first a directed set and then random
// well-formed, broken and truncated segments.
// A tracker class parses each accepted byte itself, queues the records that
// the byte must produce, and compares every record beat field by field.
// Both handshakes idle and stall at random.
// ----------------------------------------------------------------------------

module tb_tcp_header_option_parser_core
  import tcpp_pkg::*;
();

  localparam int unsigned CLK_HALF       = 1;
  localparam int unsigned MAX_GAP        = 18;
  localparam int unsigned RANDOM_BYTES   = 1600;
  localparam int unsigned DRAIN_CYCLES   = 20;
  localparam int unsigned MAX_REPORTS    = 10;
  localparam int unsigned TIMEOUT_NS     = 1_000_000;

  // Well-known ports that give an application class.
  localparam logic [15:0] PORT_FTP_DATA = 16'd20;
  localparam logic [15:0] PORT_FTP      = 16'd21;
  localparam logic [15:0] PORT_TELNET   = 16'd23;
  localparam logic [15:0] PORT_SMTP     = 16'd25;
  localparam logic [15:0] PORT_HTTP     = 16'd80;
  localparam logic [15:0] PORT_POP      = 16'd110;
  localparam logic [15:0] PORT_IMAP     = 16'd143;

  // Where the option walker stands within the current option.
  typedef enum logic [1:0] {
    AWAIT_KIND   = 2'd0,
    AWAIT_LENGTH = 2'd1,
    IN_VALUE     = 2'd2
  } opt_step_e;

  // --------------------------------------------------------------------------
  // Record tracker. It keeps its own copy of the per-segment parse state,
  // turns every accepted byte into the records that byte must release, and
  // holds those records in order until the output side consumes them.
  // --------------------------------------------------------------------------
  class record_tracker;
    rec_t        records_due[$];
    logic [15:0] byte_pos;
    logic [5:0]  hdr_bytes;
    logic [31:0] shift_reg;
    logic [31:0] held_val;
    app_class_e  seg_class;
    opt_step_e   opt_step;
    logic [7:0]  opt_kind;
    logic [7:0]  opt_len;
    logic [7:0]  opt_idx;
    logic        opts_done;
    int unsigned n_bytes;
    int unsigned n_segments;
    int unsigned n_checked;
    int unsigned n_bad;
    int unsigned longest;

    function new();
      clear_segment();
      n_bytes    = 0;
      n_segments = 0;
      n_checked  = 0;
      n_bad      = 0;
      longest    = 0;
    endfunction

    function void clear_segment();
      byte_pos  = '0;
      hdr_bytes = '0;
      shift_reg = '0;
      held_val  = '0;
      seg_class = APP_NONE;
      opt_step  = AWAIT_KIND;
      opt_kind  = '0;
      opt_len   = '0;
      opt_idx   = '0;
      opts_done = 1'b0;
    endfunction

    function app_class_e class_of(logic [15:0] port);
      case (port)
        PORT_HTTP:              return APP_HTTP;
        PORT_TELNET:            return APP_TELNET;
        PORT_SMTP:              return APP_SMTP;
        PORT_POP:               return APP_POP;
        PORT_IMAP:              return APP_IMAP;
        PORT_FTP_DATA, PORT_FTP: return APP_FTP;
        default:                return APP_NONE;
      endcase
    endfunction

    function void add(rec_kind_e kind, logic [31:0] a, logic [31:0] b, app_class_e cls,
                      logic last);
      rec_t r;
      r.kind      = kind;
      r.val_a     = a;
      r.val_b     = b;
      r.app_class = cls;
      r.last      = last;
      records_due.push_back(r);
    endfunction

    // A completed option: value bytes 2..5 sit in held_val, 6..9 in shift_reg.
    function void add_option();
      case (opt_kind)
        OPT_MSS:     add(REC_MSS, {16'd0, held_val[31:16]}, {24'd0, opt_len}, APP_NONE, 1'b0);
        OPT_WSCALE:  add(REC_WSCALE, {24'd0, held_val[31:24]}, {24'd0, opt_len}, APP_NONE,
                         1'b0);
        OPT_SACK_OK: add(REC_SACK_OK, 32'd0, {24'd0, opt_len}, APP_NONE, 1'b0);
        OPT_TSTAMP:  add(REC_TSTAMP, held_val, shift_reg, APP_NONE, 1'b0);
        default:     add(REC_UNKNOWN, {24'd0, opt_kind}, {24'd0, opt_len}, APP_NONE, 1'b0);
      endcase
    endfunction

    function void take_byte(logic [7:0] b, logic last);
      int unsigned pos;
      int unsigned hdr_end;
      int unsigned total;
      logic [3:0]  off;
      pos     = byte_pos;
      hdr_end = (hdr_bytes < 20) ? 20 : hdr_bytes;
      n_bytes++;
      if (pos < 20) begin
        shift_reg = {shift_reg[23:0], b};
        case (pos)
          3: begin
            // Source port is tried first, destination only if it gives nothing.
            seg_class = class_of(shift_reg[31:16]);
            if (seg_class == APP_NONE) seg_class = class_of(shift_reg[15:0]);
            add(REC_PORTS, {16'd0, shift_reg[31:16]}, {16'd0, shift_reg[15:0]}, seg_class,
                1'b0);
          end
          7:  add(REC_SEQ, shift_reg, 32'd0, APP_NONE, 1'b0);
          11: add(REC_ACK, shift_reg, 32'd0, APP_NONE, 1'b0);
          13: begin
            off       = shift_reg[15:12];
            hdr_bytes = {off, 2'b00};
            hdr_end   = (hdr_bytes < 20) ? 20 : hdr_bytes;
            add(REC_HDR_FLAGS, {26'd0, hdr_bytes}, {24'd0, shift_reg[7:0]}, APP_NONE, 1'b0);
            if (off < 5) begin
              opts_done = 1'b1;
              if (!last) add(REC_MALFORMED, BAD_DATA_OFFSET, {28'd0, off}, APP_NONE, 1'b0);
            end
          end
          17: add(REC_WIN_CSUM, {16'd0, shift_reg[31:16]}, {16'd0, shift_reg[15:0]},
                  APP_NONE, 1'b0);
          19: add(REC_URGENT, {16'd0, shift_reg[15:0]}, 32'd0, APP_NONE, 1'b0);
          default: ;
        endcase
      end else if (pos < hdr_end && !opts_done) begin
        case (opt_step)
          AWAIT_KIND: begin
            if (b == OPT_EOL) begin
              opts_done = 1'b1;
            end else if (b == OPT_NOP) begin
              add(REC_NOP, 32'd1, 32'd1, APP_NONE, 1'b0);
            end else begin
              opt_kind = b;
              opt_step = AWAIT_LENGTH;
            end
          end
          AWAIT_LENGTH: begin
            opt_len = b;
            if (b < 2) begin
              opts_done = 1'b1;
              add(REC_MALFORMED, BAD_OPT_LENGTH, {24'd0, b}, APP_NONE, 1'b0);
            end else if (pos - 1 + b > hdr_end) begin
              opts_done = 1'b1;
              add(REC_MALFORMED, OPT_PAST_END, {24'd0, b}, APP_NONE, 1'b0);
            end else begin
              held_val  = '0;
              shift_reg = '0;
              if (b == 2) begin
                add_option();
                opt_step = AWAIT_KIND;
              end else begin
                opt_idx  = 8'd2;
                opt_step = IN_VALUE;
              end
            end
          end
          default: begin
            if (opt_idx >= 2 && opt_idx <= 5) begin
              held_val = held_val | (32'(b) << (8 * (5 - opt_idx)));
            end else if (opt_idx >= 6 && opt_idx <= 9) begin
              shift_reg = shift_reg | (32'(b) << (8 * (9 - opt_idx)));
            end
            if (int'(opt_idx) + 1 >= int'(opt_len)) begin
              add_option();
              opt_step = AWAIT_KIND;
            end else begin
              opt_idx = opt_idx + 8'd1;
            end
          end
        endcase
      end
      if (last) begin
        total = pos + 1;
        if (total > MAX_SEG_BYTES) total = MAX_SEG_BYTES;
        if (total < hdr_end) add(REC_MALFORMED, SHORT_SEGMENT, total, APP_NONE, 1'b1);
        else add(REC_END, total - hdr_end, total, seg_class, 1'b1);
        n_segments++;
        if (pos + 1 > longest) longest = pos + 1;
        clear_segment();
      end else if (pos < MAX_SEG_BYTES) begin
        byte_pos = byte_pos + 16'd1;
      end
    endfunction

    function void check_record(rec_t got);
      rec_t want;
      if (records_due.size() == 0) begin
        n_bad++;
        if (n_bad <= MAX_REPORTS)
          $display("unexpected record: kind %0d a %h b %h class %0d last %0b",
                   got.kind, got.val_a, got.val_b, got.app_class, got.last);
        return;
      end
      want = records_due.pop_front();
      n_checked++;
      if (got.kind !== want.kind || got.val_a !== want.val_a || got.val_b !== want.val_b ||
          got.app_class !== want.app_class || got.last !== want.last) begin
        n_bad++;
        if (n_bad <= MAX_REPORTS) begin
          $display("record %0d mismatch: expected kind %0d a %h b %h class %0d last %0b",
                   n_checked, want.kind, want.val_a, want.val_b, want.app_class, want.last);
          $display("record %0d mismatch:      got kind %0d a %h b %h class %0d last %0b",
                   n_checked, got.kind, got.val_a, got.val_b, got.app_class, got.last);
        end
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Block under test
  // --------------------------------------------------------------------------
  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  data_byte_i;
  logic        seg_last_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [3:0]  record_kind_o;
  logic [31:0] value_a_o;
  logic [31:0] value_b_o;
  logic [2:0]  app_class_o;
  logic        rec_last_o;

  tcp_header_option_parser_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .data_byte_i   (data_byte_i),
    .seg_last_i    (seg_last_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .record_kind_o (record_kind_o),
    .value_a_o     (value_a_o),
    .value_b_o     (value_b_o),
    .app_class_o   (app_class_o),
    .rec_last_o    (rec_last_o)
  );

  record_tracker tracker;
  logic [7:0]    seg_q[$];  // bytes of the segment being built
  bit            in_gaps_on;

  initial begin
    clk_i = 1'b0;
    forever #CLK_HALF clk_i = ~clk_i;
  end

  // A hard ceiling on the run, far above the slowest legal run.
  initial begin
    #TIMEOUT_NS;
    $display("simulation failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Segment building. Each helper appends to seg_q.
  // --------------------------------------------------------------------------
  function automatic void add_header(logic [15:0] src, logic [15:0] dst, logic [31:0] seq,
                                     logic [31:0] ack, logic [3:0] off, logic [3:0] rsv,
                                     logic [7:0] flags, logic [15:0] win, logic [15:0] csum,
                                     logic [15:0] urg);
    seg_q.push_back(src[15:8]);  seg_q.push_back(src[7:0]);
    seg_q.push_back(dst[15:8]);  seg_q.push_back(dst[7:0]);
    seg_q.push_back(seq[31:24]); seg_q.push_back(seq[23:16]);
    seg_q.push_back(seq[15:8]);  seg_q.push_back(seq[7:0]);
    seg_q.push_back(ack[31:24]); seg_q.push_back(ack[23:16]);
    seg_q.push_back(ack[15:8]);  seg_q.push_back(ack[7:0]);
    seg_q.push_back({off, rsv}); seg_q.push_back(flags);
    seg_q.push_back(win[15:8]);  seg_q.push_back(win[7:0]);
    seg_q.push_back(csum[15:8]); seg_q.push_back(csum[7:0]);
    seg_q.push_back(urg[15:8]);  seg_q.push_back(urg[7:0]);
  endfunction

  // Roughly a third of ports are recognised ones so that every class and
  // the source-before-destination rule come up often.
  function automatic logic [15:0] pick_port();
    if ($urandom_range(2, 0) != 0) return 16'($urandom);
    case ($urandom_range(6, 0))
      0:       return PORT_HTTP;
      1:       return PORT_TELNET;
      2:       return PORT_SMTP;
      3:       return PORT_POP;
      4:       return PORT_IMAP;
      5:       return PORT_FTP_DATA;
      default: return PORT_FTP;
    endcase
  endfunction

  // Fills the option area. Well-formed lists always fit; broken ones get the
  // odd length that is too small or random and may run past the header end.
  function automatic void add_options(int unsigned room, bit broken);
    int unsigned pick;
    int unsigned full;
    int unsigned len;
    int unsigned nval;
    logic [7:0]  kind;
    while (room > 0) begin
      pick = $urandom_range(9, 0);
      full = 2;
      case (pick)
        0:       kind = OPT_EOL;
        1, 2:    kind = OPT_NOP;
        3:       begin kind = OPT_MSS;     full = 4;  end
        4:       begin kind = OPT_WSCALE;  full = 3;  end
        5:       begin kind = OPT_SACK_OK; full = 2;  end
        6, 7:    begin kind = OPT_TSTAMP;  full = 10; end
        default: begin kind = 8'($urandom_range(255, 5)); full = $urandom_range(12, 2); end
      endcase
      if (kind == OPT_EOL) begin
        // Everything after end-of-list is padding that the parser skips.
        seg_q.push_back(OPT_EOL);
        room--;
        repeat (room) seg_q.push_back(8'($urandom));
        room = 0;
      end else if (kind == OPT_NOP) begin
        seg_q.push_back(OPT_NOP);
        room--;
      end else begin
        len = full;
        if ($urandom_range(7, 0) == 0) len = $urandom_range(full, 2);
        else if ($urandom_range(9, 0) == 0) len = full + $urandom_range(4, 1);
        if (broken && $urandom_range(3, 0) == 0)
          len = $urandom_range(1, 0) ? $urandom_range(1, 0) : $urandom_range(255, 0);
        if (!broken && len > room) begin
          if (room < 2) len = 0;
          else len = room;
        end
        if (!broken && len == 0) begin
          seg_q.push_back(OPT_NOP);
          room--;
        end else begin
          seg_q.push_back(kind);
          room--;
          if (room != 0) begin
            seg_q.push_back(8'(len));
            room--;
            nval = (len > 2) ? len - 2 : 0;
            if (nval > room) nval = room;
            repeat (nval) seg_q.push_back(8'($urandom));
            room = room - nval;
          end
        end
      end
    end
  endfunction

  // Mostly well-formed segments with random content; the rest have broken
  // option lists, a data offset below five, or are cut short.
  function automatic void build_random_segment();
    int unsigned style;
    int unsigned off;
    int unsigned hdr_end;
    int unsigned cut;
    seg_q.delete();
    style = $urandom_range(99, 0);
    off   = (style >= 90 && style < 95) ? $urandom_range(4, 0) : $urandom_range(15, 5);
    add_header(pick_port(), pick_port(), $urandom, $urandom, off[3:0],
               4'($urandom_range(15, 0)), 8'($urandom_range(255, 0)), 16'($urandom),
               16'($urandom), 16'($urandom));
    if (off > 5) add_options(off * 4 - 20, style >= 80 && style < 90);
    repeat ($urandom_range(16, 0)) seg_q.push_back(8'($urandom));
    if (style >= 95) begin
      hdr_end = (off * 4 < 20) ? 20 : off * 4;
      cut     = $urandom_range(hdr_end - 1, 1);
      while (seg_q.size() > cut) void'(seg_q.pop_back());
    end
  endfunction

  // --------------------------------------------------------------------------
  // Input side. Inputs change on the falling edge; a beat is taken at the
  // rising edge where valid and ready are both high. Valid is only lowered
  // when a gap follows, so it never falls and rises in the same time step.
  // --------------------------------------------------------------------------
  task automatic push_byte(input logic [7:0] b, input logic last);
    int unsigned gap;
    gap = in_gaps_on ? $urandom_range(MAX_GAP, 0) : 0;
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    seg_last_i  <= last;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    tracker.take_byte(b, last);
  endtask

  task automatic send_segment(input bit gaps);
    in_gaps_on = gaps;
    foreach (seg_q[i]) push_byte(seg_q[i], i == seg_q.size() - 1);
  endtask

  task automatic run_directed();
    // Plain 20-byte header, HTTP source port, field extremes, short payload.
    seg_q.delete();
    add_header(PORT_HTTP, 16'd0, 32'hFFFF_FFFF, 32'd0, 4'd5, 4'hF, 8'hFF, 16'hFFFF,
               16'h0000, 16'hFFFF);
    seg_q.push_back(8'h00); seg_q.push_back(8'hFF);
    send_segment(1'b1);
    // Full 60-byte header with every option kind, an over-long timestamp
    // whose extra bytes are dropped, and an MSS with its value bytes missing.
    seg_q.delete();
    add_header(16'hFFFF, PORT_FTP, 32'h0123_4567, 32'h89AB_CDEF, 4'd15, 4'h0, 8'h00,
               16'h0000, 16'hFFFF, 16'h0000);
    seg_q.push_back(OPT_NOP);
    seg_q.push_back(OPT_MSS); seg_q.push_back(8'd4); seg_q.push_back(8'hFF);
    seg_q.push_back(8'hFF);
    seg_q.push_back(OPT_WSCALE); seg_q.push_back(8'd3); seg_q.push_back(8'd14);
    seg_q.push_back(OPT_SACK_OK); seg_q.push_back(8'd2);
    seg_q.push_back(OPT_TSTAMP); seg_q.push_back(8'd12);
    for (int i = 0; i < 10; i++) seg_q.push_back(8'(8'h11 * (i + 1)));
    seg_q.push_back(8'hFF); seg_q.push_back(8'd3); seg_q.push_back(8'hAA);
    seg_q.push_back(OPT_MSS); seg_q.push_back(8'd2);
    seg_q.push_back(OPT_EOL);
    repeat (12) seg_q.push_back(8'hFF);
    send_segment(1'b1);
    // Data offset below five with the segment going on; SMTP beats HTTP.
    seg_q.delete();
    add_header(PORT_SMTP, PORT_HTTP, 32'd1, 32'd2, 4'd4, 4'h0, 8'h12, 16'd3, 16'd4, 16'd5);
    seg_q.push_back(8'h55); seg_q.push_back(8'hAA);
    send_segment(1'b0);
    // Data offset of zero on the last byte of a segment that is too short.
    seg_q.delete();
    add_header(PORT_TELNET, PORT_POP, 32'd7, 32'd8, 4'd0, 4'h0, 8'h02, 16'd0, 16'd0, 16'd0);
    repeat (6) void'(seg_q.pop_back());
    send_segment(1'b1);
    // Option length below two.
    seg_q.delete();
    add_header(PORT_POP, 16'd9, 32'd0, 32'd0, 4'd6, 4'h0, 8'h10, 16'd0, 16'd0, 16'd0);
    seg_q.push_back(OPT_MSS); seg_q.push_back(8'd1); seg_q.push_back(8'h00);
    seg_q.push_back(8'h00);
    send_segment(1'b0);
    // Option reaching past the header end.
    seg_q.delete();
    add_header(PORT_IMAP, 16'd9, 32'd0, 32'd0, 4'd6, 4'h0, 8'h10, 16'd0, 16'd0, 16'd0);
    seg_q.push_back(OPT_NOP); seg_q.push_back(OPT_TSTAMP); seg_q.push_back(8'd10);
    seg_q.push_back(8'h00);
    send_segment(1'b1);
    // Segment ending in the middle of the options.
    seg_q.delete();
    add_header(PORT_FTP_DATA, 16'd0, 32'd0, 32'd0, 4'd8, 4'h0, 8'h18, 16'd0, 16'd0, 16'd0);
    seg_q.push_back(OPT_WSCALE); seg_q.push_back(8'd3); seg_q.push_back(8'd7);
    seg_q.push_back(OPT_NOP); seg_q.push_back(OPT_NOP);
    send_segment(1'b0);
    // Four bytes only: ports and the final record come from the same byte.
    seg_q.delete();
    add_header(16'd1, PORT_IMAP, 32'd0, 32'd0, 4'd5, 4'h0, 8'h00, 16'd0, 16'd0, 16'd0);
    while (seg_q.size() > 4) void'(seg_q.pop_back());
    send_segment(1'b0);
  endtask

  // --------------------------------------------------------------------------
  // Output side. Ready is held low for a random stall before each beat,
  // with stall-free stretches now and then; records are sampled at the rising
  // edge on which they are taken.
  // --------------------------------------------------------------------------
  initial begin : record_sink
    int unsigned stall;
    bit          stalls_on;
    rec_t        got;
    out_ready_i = 1'b0;
    stalls_on   = 1'b1;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if ($urandom_range(39, 0) == 0) stalls_on = !stalls_on;
      stall = stalls_on ? $urandom_range(MAX_GAP, 0) : 0;
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
      got.kind      = rec_kind_e'(record_kind_o);
      got.val_a     = value_a_o;
      got.val_b     = value_b_o;
      got.app_class = app_class_e'(app_class_o);
      got.last      = rec_last_o;
      tracker.check_record(got);
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : main_seq
    int unsigned target;
    tracker     = new();
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    data_byte_i = 8'h00;
    seg_last_i  = 1'b0;
    in_gaps_on  = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    run_directed();

    // Random segments, each one either with input gaps or back to back.
    target = tracker.n_bytes + RANDOM_BYTES;
    while (tracker.n_bytes < target) begin
      build_random_segment();
      send_segment($urandom_range(3, 0) != 0);
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;

    // Let every outstanding record drain, then wait out DRAIN_CYCLES to catch
    // anything the block releases beyond what was predicted.
    while (tracker.records_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("%0d segments, %0d bytes and %0d records checked, longest segment %0d bytes",
             tracker.n_segments, tracker.n_bytes, tracker.n_checked, tracker.longest);
    $display("%0d record errors; options, malformed headers and short segments covered",
             tracker.n_bad);
    if (tracker.n_bad == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+src
src/tcpp_pkg.sv
src/tcpp_rec_fifo.sv
src/tcp_header_option_parser_core.sv
tb/tb_tcp_header_option_parser_core.sv
